### hdl/laplacian_edge_detect_3x3_core_defines.svh
// Assertion macros for the Laplacian edge filter core.
`ifndef LAPLACIAN_EDGE_DETECT_3X3_CORE_DEFINES_SVH
`define LAPLACIAN_EDGE_DETECT_3X3_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define LAPEDGE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define LAPEDGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lapedge_pkg.sv
// Shared types and constants of the Laplacian edge filter.
package lapedge_pkg;

  localparam int ChanW     = 8;
  localparam int PixW      = 3 * ChanW;
  localparam int NumLanes  = 3;
  localparam int WinDim    = 3;
  localparam int NumTaps   = WinDim * WinDim;
  localparam int CenterTap = NumTaps / 2;
  localparam int FwW       = 11;
  localparam int FhW       = 12;
  localparam int CfgDataW  = 12;
  localparam int CfgIdxW   = 1;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef logic [PixW-1:0] pixel_t;
  typedef logic [NumTaps-1:0][ChanW-1:0] tap_vec_t;

  // Which window borders still lie inside the frame.
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } border_t;

endpackage

### hdl/laplacian_edge_detect_3x3_core.sv
// Top level: streaming 3x3 Laplacian edge filter on RGB pixels, three color lanes.
// Throughput: one item per cycle unless the output stalls; the line buffer RAM takes one
// read and one write each cycle. A result goes through stage 1, stage 2 and the output
// register once item k+width+1, completing the window of raster position k, is accepted.
// Reset: counters, window and pipeline clear at once; line buffer RAM is not cleared, and
// its unwritten words can be read, but only into window taps that the border flags mask.
`include "laplacian_edge_detect_3x3_core_defines.svh"

module laplacian_edge_detect_3x3_core
  import lapedge_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [ChanW-1:0]    red_in_i,
  input  logic [ChanW-1:0]    green_in_i,
  input  logic [ChanW-1:0]    blue_in_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ChanW-1:0]    red_out_o,
  output logic [ChanW-1:0]    green_out_o,
  output logic [ChanW-1:0]    blue_out_o,
  output logic                frame_end_o
);

  // CW addresses a row, WW holds width+1, EW compares the raw width register
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 2);
  localparam int EW = (WW > FwW) ? WW : FwW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [FwW-1:0] frame_width_q;
  logic [FhW-1:0] frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 11'd640;
      frame_height_q <= 12'd480;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FwW-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FhW-1:0];
      endcase
    end
  end

  // Effective sizes: zero acts as one, width saturates at MAX_WIDTH
  logic [EW-1:0]  fw_ext;
  logic [WW-1:0]  eff_w;
  logic [FhW-1:0] eff_h;

  always_comb begin
    fw_ext = EW'(frame_width_q);
    if (frame_width_q == '0) begin
      eff_w = WW'(1);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext[WW-1:0];
    end
    eff_h = (frame_height_q == '0) ? FhW'(1) : frame_height_q;
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: accept -> stage 1 (RAM read) -> stage 2 (window) -> out
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_free, s2_free, s1_adv, s2_adv, acc_in;

  assign out_free   = !out_v_q || out_ready_i;
  assign s2_adv     = s2_v_q && out_free;
  assign s2_free    = !s2_v_q || out_free;
  assign s1_adv     = s1_v_q && s2_free;
  assign in_ready_o = !s1_v_q || s2_free;
  assign acc_in     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Raster counters, advanced once per accepted item
  // ---------------------------------------------------------------------------
  logic [WW-1:0]  fill_count_q, fill_count_d;
  logic [CW-1:0]  out_col_q, out_col_d;
  logic [FhW-1:0] out_row_q, out_row_d;

  logic           primed;
  logic [WW-1:0]  col_p1, col_next;
  logic [CW-1:0]  col_sel;
  logic [FhW:0]   row_p1;
  border_t        border;
  logic           last;
  pixel_t         px;

  always_comb begin
    primed      = fill_count_q >= (eff_w + WW'(1));
    col_p1      = WW'(out_col_q) + WW'(1);
    col_next    = primed ? col_p1 : fill_count_q;
    col_sel     = (col_next >= eff_w) ? '0 : col_next[CW-1:0];
    row_p1      = {1'b0, out_row_q} + (FhW+1)'(1);
    border.up    = out_row_q != '0;
    border.down  = row_p1 < {1'b0, eff_h};
    border.left  = out_col_q != '0;
    border.right = col_p1 < eff_w;
    last        = !border.down && !border.right;
    // a flush item enters as a black pixel
    px = (cmd_e'(command_i) == CMD_FLUSH) ? '0 : {red_in_i, green_in_i, blue_in_i};
  end

  always_comb begin
    fill_count_d = fill_count_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    if (acc_in) begin
      if (!primed) begin
        fill_count_d = fill_count_q + WW'(1);
      end else if (last) begin
        fill_count_d = '0;
        out_col_d    = '0;
        out_row_d    = '0;
      end else if (!border.right) begin
        out_col_d = '0;
        out_row_d = row_p1[FhW-1:0];
      end else begin
        out_col_d = out_col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_count_q <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
    end else begin
      fill_count_q <= fill_count_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line buffer read returns; upper/middle pair is rewritten on exit
  // ---------------------------------------------------------------------------
  logic [CW-1:0] s1_col_q;
  pixel_t        s1_px_q;
  logic          s1_primed_q, s1_last_q;
  border_t       s1_border_q;
  logic          fwd_q;
  pixel_t        fwd_top_q, fwd_mid_q;
  logic [2*PixW-1:0] lb_rdata;
  pixel_t        s1_top, s1_mid;

  // The item ahead writes its entry on the same edge this item reads it,
  // so a column clash takes that item's values instead of the RAM word.
  always_comb begin
    s1_top = fwd_q ? fwd_top_q : lb_rdata[2*PixW-1:PixW];
    s1_mid = fwd_q ? fwd_mid_q : lb_rdata[PixW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else if (acc_in) begin
      s1_v_q <= 1'b1;
      fwd_q  <= s1_v_q && (s1_col_q == col_sel);
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      s1_col_q    <= col_sel;
      s1_px_q     <= px;
      s1_primed_q <= primed;
      s1_last_q   <= last;
      s1_border_q <= border;
      fwd_top_q   <= s1_mid;
      fwd_mid_q   <= s1_px_q;
    end
  end

  lapedge_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (2 * PixW)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (acc_in),
    .rd_addr_i (col_sel),
    .rd_data_o (lb_rdata),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({s1_mid, s1_px_q})
  );

  // ---------------------------------------------------------------------------
  // Stage 2: 3x3 window, shifted left by one column per item
  // ---------------------------------------------------------------------------
  pixel_t  win_q [NumTaps];
  border_t s2_border_q;
  logic    s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTaps; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int r = 0; r < WinDim; r++) begin
        win_q[r * WinDim]     <= win_q[r * WinDim + 1];
        win_q[r * WinDim + 1] <= win_q[r * WinDim + 2];
      end
      win_q[WinDim - 1]     <= s1_top;
      win_q[2 * WinDim - 1] <= s1_mid;
      win_q[NumTaps - 1]    <= s1_px_q;
    end
  end

  // priming items shift the window but carry no result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s1_adv) begin
      s2_v_q <= s1_primed_q;
    end else if (s2_adv) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_border_q <= s1_border_q;
      s2_last_q   <= s1_last_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Color lanes: red, green, blue side by side on the same window
  // ---------------------------------------------------------------------------
  tap_vec_t         lane_taps [NumLanes];
  logic [ChanW-1:0] lane_res  [NumLanes];

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    always_comb begin
      for (int i = 0; i < NumTaps; i++) begin
        lane_taps[l][i] = win_q[i][ChanW * (NumLanes - 1 - l) +: ChanW];
      end
    end

    lapedge_lane u_lane (
      .taps_i   (lane_taps[l]),
      .border_i (s2_border_q),
      .result_o (lane_res[l])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge stage: output register gathers the lanes and the frame-end flag
  // ---------------------------------------------------------------------------
  logic [ChanW-1:0] red_q, green_q, blue_q;
  logic             frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_adv) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      red_q       <= lane_res[0];
      green_q     <= lane_res[1];
      blue_q      <= lane_res[2];
      frame_end_q <= s2_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign frame_end_o = frame_end_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LAPEDGE_ASSERT_NOW(a_fwd_needs_s1, fwd_q, s1_v_q, "forward flag without stage 1 item")
  `LAPEDGE_ASSERT_NOW(a_full_stall, out_v_q && !out_ready_i && s2_v_q && s1_v_q, !in_ready_o, "accepting into a full stalled pipeline")
  `LAPEDGE_ASSERT_NOW(a_fill_bound, 1'b1, fill_count_q <= WW'(MAX_WIDTH + 1), "fill count beyond row plus one")
  `LAPEDGE_ASSERT_NEXT(a_accept_s1, acc_in, s1_v_q, "accepted item missing from stage 1")

endmodule

### hdl/lapedge_linebuf.sv
// Two-row line buffer: one wide RAM, registered read, one write per cycle.
module lapedge_linebuf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 48
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read-before-write on an address clash; the core forwards around it
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/lapedge_lane.sv
// One color lane: 8-neighbor Laplacian with border masking and clamp.
module lapedge_lane
  import lapedge_pkg::*;
(
  input  tap_vec_t         taps_i,
  input  border_t          border_i,
  output logic [ChanW-1:0] result_o
);

  logic        [ChanW+2:0] nb_sum;
  logic signed [ChanW+3:0] acc;
  logic                    take;

  always_comb begin
    nb_sum = '0;
    for (int r = 0; r < WinDim; r++) begin
      for (int c = 0; c < WinDim; c++) begin
        take = !(r == 1 && c == 1) &&
               (r != 0 || border_i.up) && (r != WinDim - 1 || border_i.down) &&
               (c != 0 || border_i.left) && (c != WinDim - 1 || border_i.right);
        if (take) begin
          nb_sum = nb_sum + (ChanW+3)'(taps_i[r * WinDim + c]);
        end
      end
    end
    acc = $signed({1'b0, taps_i[CenterTap], 3'b000}) - $signed({1'b0, nb_sum});
  end

  always_comb begin
    if (acc < 0) begin
      result_o = '0;
    end else if (acc > $signed({4'b0000, ChanMax})) begin
      result_o = ChanMax;
    end else begin
      result_o = acc[ChanW-1:0];
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the streaming 3x3 Laplacian edge filter core.
module tb_top;
  import lapedge_pkg::*;

  localparam int LineDepth    = 1024;
  localparam int SettleCycles = 8;
  localparam int RandomItems  = 740;

  typedef struct packed {
    cmd_e             cmd;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_item_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             frame_end;
  } edge_result_t;

  // stimulus side
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_valid = 1'b0;
  cfg_reg_e            cfg_index = REG_FRAME_WIDTH;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  pixel_item_t         cur_item  = '{CMD_FLUSH, 8'h00, 8'h00, 8'h00};
  logic                out_ready = 1'b0;

  // block outputs
  logic             cfg_ready;
  logic             in_ready;
  logic             out_valid;
  logic [ChanW-1:0] red_out;
  logic [ChanW-1:0] green_out;
  logic [ChanW-1:0] blue_out;
  logic             frame_end;

  pixel_item_t  pixel_q[$];
  edge_result_t edge_q[$];
  int pushed_cnt   = 0;
  int accepted_cnt = 0;
  int errors       = 0;
  int idle_pct     = 0;
  int in_gap       = 0;
  int out_gap      = 0;

  // shadow of the registers and of the filter state
  logic [FwW-1:0]  shadow_width  = 11'd640;
  logic [FhW-1:0]  shadow_height = 12'd480;
  logic [PixW-1:0] upper_buf  [LineDepth];
  logic [PixW-1:0] middle_buf [LineDepth];
  logic [PixW-1:0] win        [NumTaps];
  logic [11:0]     out_row    = '0;
  logic [9:0]      out_col    = '0;
  logic [10:0]     fill_count = '0;

  laplacian_edge_detect_3x3_core #(
    .MAX_WIDTH(LineDepth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .command_i  (cur_item.cmd),
    .red_in_i   (cur_item.red),
    .green_in_i (cur_item.green),
    .blue_in_i  (cur_item.blue),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .red_out_o  (red_out),
    .green_out_o(green_out),
    .blue_out_o (blue_out),
    .frame_end_o(frame_end)
  );

  always #5 clk = ~clk;

  // Zero means one; anything past the line buffer depth is clipped to it.
  function automatic int active_width();
    int w;
    w = int'(shadow_width);
    if (w == 0) w = 1;
    if (w > LineDepth) w = LineDepth;
    return w;
  endfunction

  function automatic int active_height();
    return (shadow_height == 0) ? 1 : int'(shadow_height);
  endfunction

  // One lane of the kernel: 8x center minus every neighbor still inside the frame.
  function automatic logic [ChanW-1:0] edge_response(int lane_lsb, border_t b);
    int acc;
    acc = 8 * int'(win[CenterTap][lane_lsb +: ChanW]);
    for (int r = 0; r < WinDim; r++) begin
      for (int c = 0; c < WinDim; c++) begin
        if (r == 1 && c == 1) continue;
        if ((r == 0 && !b.up) || (r == 2 && !b.down)) continue;
        if ((c == 0 && !b.left) || (c == 2 && !b.right)) continue;
        acc -= int'(win[r * WinDim + c][lane_lsb +: ChanW]);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > int'(ChanMax)) acc = int'(ChanMax);
    return acc[ChanW-1:0];
  endfunction

  // Advance the shadow filter by one accepted item; queue the response it releases.
  task automatic filter_accept(pixel_item_t it);
    int           w, h, col;
    logic [PixW-1:0] px, top, mid;
    bit           primed, last;
    border_t      b;
    edge_result_t res;
    w = active_width();
    h = active_height();
    primed = (fill_count >= w + 1);
    px = (it.cmd == CMD_PIXEL) ? {it.red, it.green, it.blue} : '0;
    col = primed ? out_col + 1 : int'(fill_count);
    if (col >= w) col = 0;
    // two line buffers shift down one row at this column
    top = upper_buf[col];
    mid = middle_buf[col];
    upper_buf[col]  = mid;
    middle_buf[col] = px;
    for (int r = 0; r < WinDim; r++) begin
      win[r * WinDim]     = win[r * WinDim + 1];
      win[r * WinDim + 1] = win[r * WinDim + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    if (!primed) begin
      fill_count = fill_count + 1'b1;
      return;
    end
    b.up    = (out_row > 0);
    b.down  = (out_row + 1 < h);
    b.left  = (out_col > 0);
    b.right = (out_col + 1 < w);
    last = !b.down && !b.right;
    res.red       = edge_response(2 * ChanW, b);
    res.green     = edge_response(ChanW, b);
    res.blue      = edge_response(0, b);
    res.frame_end = last;
    edge_q.push_back(res);
    if (last) begin
      out_row    = '0;
      out_col    = '0;
      fill_count = '0;
    end else if (!b.right) begin
      out_col = '0;
      out_row = out_row + 1'b1;
    end else begin
      out_col = out_col + 1'b1;
    end
  endtask

  task automatic check_field(string name, logic [ChanW-1:0] want, logic [ChanW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Pixel driver: pops pending items, holds each until taken, inserts idle bursts.
  always @(posedge clk) begin : pixel_driver
    if (rst_n) begin
      if (in_valid && in_ready) begin
        filter_accept(cur_item);
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0 && idle_pct != 0 &&
                     $urandom_range(99) < idle_pct) begin
          in_gap = $urandom_range(8);
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          cur_item <= pixel_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each taken result against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    edge_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (edge_q.size() == 0) begin
          $display("%0t: result mismatch: expected none, actual %0d/%0d/%0d end %0d",
                   $time, red_out, green_out, blue_out, frame_end);
          errors++;
        end else begin
          want = edge_q.pop_front();
          check_field("red", want.red, red_out);
          check_field("green", want.green, green_out);
          check_field("blue", want.blue, blue_out);
          check_field("frame_end", ChanW'(want.frame_end), ChanW'(frame_end));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        out_gap = $urandom_range(8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [ChanW-1:0] rand_chan(bit harsh);
    logic [31:0] v;
    v = $urandom;
    if (harsh) return v[0] ? ChanMax : '0;
    return v[ChanW-1:0];
  endfunction

  task automatic push_item(cmd_e cmd, logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                           logic [ChanW-1:0] b);
    pixel_q.push_back(pixel_item_t'{cmd, r, g, b});
    pushed_cnt++;
  endtask

  // One frame plus its drain. A broken frame gets stray flushes and a random drain length.
  task automatic push_frame(int w, int h, bit broken);
    bit harsh;
    int drain;
    harsh = ($urandom_range(3) == 0);
    for (int p = 0; p < w * h; p++) begin
      if (broken && $urandom_range(19) == 0)
        push_item(CMD_FLUSH, rand_chan(0), rand_chan(0), rand_chan(0));
      push_item(CMD_PIXEL, rand_chan(harsh), rand_chan(harsh), rand_chan(harsh));
    end
    drain = broken ? $urandom_range(w + 3) : w + 1;
    for (int d = 0; d < drain; d++) begin
      if ($urandom_range(6) == 0)
        push_item(CMD_PIXEL, rand_chan(0), rand_chan(0), rand_chan(0));
      else
        push_item(CMD_FLUSH, rand_chan(0), rand_chan(0), rand_chan(0));
    end
  endtask

  task automatic wait_settled(int extra);
    do @(negedge clk); while (accepted_cnt != pushed_cnt || edge_q.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FRAME_WIDTH) shadow_width = data[FwW-1:0];
    else shadow_height = data[FhW-1:0];
    cfg_valid <= 1'b0;
  endtask

  // Registers only change once the pipeline has gone quiet.
  task automatic set_frame(logic [CfgDataW-1:0] wdata, logic [CfgDataW-1:0] hdata);
    wait_settled(SettleCycles);
    if ($urandom_range(1)) begin
      write_reg(REG_FRAME_WIDTH, wdata);
      write_reg(REG_FRAME_HEIGHT, hdata);
    end else begin
      write_reg(REG_FRAME_HEIGHT, hdata);
      write_reg(REG_FRAME_WIDTH, wdata);
    end
    @(negedge clk);
  endtask

  // Feed flushes one at a time until the open frame closes.
  task automatic finish_open_frame();
    while (fill_count != 0) begin
      push_item(CMD_FLUSH, rand_chan(0), rand_chan(0), rand_chan(0));
      wait_settled(0);
    end
  endtask

  initial begin : stimulus
    int base, w, h;
    logic [CfgDataW-1:0] wdata, hdata;
    for (int i = 0; i < LineDepth; i++) begin
      upper_buf[i]  = '0;
      middle_buf[i] = '0;
    end
    for (int i = 0; i < NumTaps; i++) win[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: 3x3 frame, red a lone bright center, green flat, blue a dark center.
    idle_pct = 10;
    set_frame(12'd3, 12'd3);
    for (int p = 0; p < 9; p++)
      push_item(CMD_PIXEL, (p == 4) ? ChanMax : 8'h00, ChanMax, (p == 4) ? 8'h00 : ChanMax);
    repeat (4) push_item(CMD_FLUSH, ChanMax, ChanMax, ChanMax);
    // Width with the spare data bit set, zero height; drained by pixel items.
    set_frame(12'h801, 12'h000);
    push_item(CMD_PIXEL, 8'hFF, 8'h00, 8'h80);
    push_item(CMD_PIXEL, 8'h01, 8'hFE, 8'h7F);
    push_item(CMD_PIXEL, 8'hAA, 8'h55, 8'hC3);
    // Zero width acts as one.
    set_frame(12'h000, 12'd1);
    push_item(CMD_PIXEL, 8'h80, 8'h01, 8'hFE);
    repeat (2) push_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);

    // Widest lines used below (writes every line buffer column they touch),
    // then a tall one-pixel-wide frame.
    idle_pct = $urandom_range(1) ? 10 : 0;
    set_frame(12'd40, 12'd2);
    push_frame(40, 2, 1'b0);
    idle_pct = $urandom_range(1) ? 10 : 0;
    set_frame(12'd1, 12'd30);
    push_frame(1, 30, 1'b0);

    // Random phases of small frames; some leave a frame open across a register write.
    base = pushed_cnt;
    while (pushed_cnt - base < RandomItems) begin
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      case ($urandom_range(9))
        0:       wdata = 12'd0;
        1:       wdata = 12'($urandom_range(40, 11));
        default: wdata = 12'($urandom_range(10, 1));
      endcase
      if ($urandom_range(1)) wdata[CfgDataW-1] = 1'b1;
      case ($urandom_range(19))
        0, 1:    hdata = 12'd0;
        2:       hdata = 12'($urandom_range(20, 7));
        default: hdata = 12'($urandom_range(6, 1));
      endcase
      set_frame(wdata, hdata);
      w = active_width();
      h = active_height();
      repeat ($urandom_range(3, 1)) push_frame(w, h, $urandom_range(4) == 0);
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(w * h + w, 1))
          push_item(CMD_PIXEL, rand_chan(0), rand_chan(0), rand_chan(0));
      end else begin
        wait_settled(0);
        finish_open_frame();
      end
    end

    // Closing stretch at full rate on both sides.
    wait_settled(SettleCycles);
    finish_open_frame();
    idle_pct = 0;
    set_frame(12'd4, 12'd3);
    push_frame(4, 3, 1'b0);
    wait_settled(20);

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
